// File: rtl/fsqrt_pkg.sv
`timescale 1ns / 1ps
package fsqrt_pkg;

    localparam int SIG_W      = 25;
    localparam int ROOT_W     = 25;
    localparam int REM_W      = 32;
    localparam int NUM_ITERS  = 25;

    localparam logic [31:0] MAG_MASK  = 32'h7fffffff;
    localparam logic [31:0] INF_BITS  = 32'h7f800000;
    localparam logic [31:0] QNAN_DEF  = 32'h7fc00000;
    localparam logic [31:0] QUIET_BIT = 32'h00400000;
    localparam logic [23:0] HIDDEN    = 24'h800000;

    // sideband that travels with every transaction
    typedef struct packed {
        logic        special;
        logic [31:0] spec_bits;
        logic        spec_inv;
        logic [7:0]  exp_base;
    } t_side;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [REM_W-1:0]  acc;
        logic [ROOT_W-1:0] root;
    } t_work;

    // leading zeros of a 24-bit value, nonzero input assumed
    function automatic logic [4:0] lz24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found) begin
                if (v[i]) begin
                    found = 1'b1;
                end else begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

endpackage

// File: rtl/fsqrt_stage.sv
`timescale 1ns / 1ps
module fsqrt_stage #(
    parameter int BIT_POS = 24
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  fsqrt_pkg::t_work i_work,
    input  fsqrt_pkg::t_side i_side,
    output logic           o_valid,
    output fsqrt_pkg::t_work o_work,
    output fsqrt_pkg::t_side o_side
);
    import fsqrt_pkg::*;

    localparam logic [REM_W-1:0] BIT_VAL = REM_W'(1) << BIT_POS;

    logic             r_valid;
    t_work            r_work;
    t_side            r_side;
    t_work            n_work;
    logic [REM_W-1:0] trial;
    logic [REM_W-1:0] rem_sub;

    always_comb begin
        trial   = i_work.acc + BIT_VAL;
        n_work  = i_work;
        rem_sub = i_work.rem;
        if (trial <= i_work.rem) begin
            n_work.acc  = trial + BIT_VAL;
            rem_sub     = i_work.rem - trial;
            n_work.root = i_work.root | BIT_VAL[ROOT_W-1:0];
        end
        n_work.rem = rem_sub << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_work <= n_work;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_work  = r_work;
    assign o_side  = r_side;
endmodule

// File: rtl/float32_square_root_core.sv
`timescale 1ns / 1ps
// single-precision square root, fully pipelined
// input channel: i_valid / o_stall with i_operand_bits (raw binary32 bits)
// output channel: o_valid / i_stall with o_root_bits, o_invalid, o_inexact
// a transaction is taken on a rising edge with valid high and stall low
// the pipeline has 27 register stages:
// one decode stage (loaded at the accepting edge) that sorts out special
// operands and normalizes subnormals, one stage per root bit of the
// restoring recurrence (25), and one rounding/packing stage
// throughput: one transaction per cycle while the receiver does not stall;
// each root-bit stage holds one compare-and-subtract on the partial remainder
// when the receiver stalls with a result waiting, the whole pipeline
// holds and o_stall is raised; nothing is lost or repeated
// reset (synchronous, active low) clears all valid bits; results in
// flight are dropped
// special operands: NaN is returned quieted, zero keeps its sign,
// +inf gives +inf, negative nonzero gives the default quiet NaN
module float32_square_root_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_bits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_root_bits,
    output logic        o_invalid,
    output logic        o_inexact
);
    import fsqrt_pkg::*;

    logic adv;
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // decode
    logic [31:0]      mag;
    logic [7:0]       efield;
    logic [23:0]      frac24;
    logic [4:0]       lz;
    logic [23:0]      sig24;
    logic signed [9:0] expo;
    logic signed [9:0] half;
    logic [SIG_W-1:0] sig;
    t_side            n_side;
    t_work            n_work;

    always_comb begin
        mag    = i_operand_bits & MAG_MASK;
        efield = mag[30:23];
        frac24 = {1'b0, mag[22:0]};
        lz     = lz24(frac24);
        if (efield == 8'd0) begin
            sig24 = frac24 << lz;
            expo  = 10'sd1 - 10'sd127 - $signed({5'd0, lz});
        end else begin
            sig24 = frac24 | HIDDEN;
            expo  = $signed({2'b00, efield}) - 10'sd127;
        end
        sig  = expo[0] ? {sig24, 1'b0} : {1'b0, sig24};
        half = expo >>> 1;

        n_side.special   = 1'b1;
        n_side.spec_bits = 32'd0;
        n_side.spec_inv  = 1'b0;
        n_side.exp_base  = 8'(10'sd126 + half);
        if (mag > INF_BITS) begin
            n_side.spec_bits = i_operand_bits | QUIET_BIT;
            n_side.spec_inv  = !i_operand_bits[22];
        end else if (mag == 32'd0) begin
            n_side.spec_bits = i_operand_bits;
        end else if (i_operand_bits[31]) begin
            n_side.spec_bits = QNAN_DEF;
            n_side.spec_inv  = 1'b1;
        end else if (mag == INF_BITS) begin
            n_side.spec_bits = INF_BITS;
        end else begin
            n_side.special = 1'b0;
        end

        n_work.rem  = REM_W'({sig, 1'b0});
        n_work.acc  = '0;
        n_work.root = '0;
    end

    logic  r_dec_valid;
    t_side r_dec_side;
    t_work r_dec_work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_valid <= 1'b0;
        end else if (adv) begin
            r_dec_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dec_side <= n_side;
            r_dec_work <= n_work;
        end
    end

    // one stage per root bit
    logic  st_valid [NUM_ITERS+1];
    t_side st_side  [NUM_ITERS+1];
    t_work st_work  [NUM_ITERS+1];

    assign st_valid[0] = r_dec_valid;
    assign st_side[0]  = r_dec_side;
    assign st_work[0]  = r_dec_work;

    for (genvar k = 0; k < NUM_ITERS; k++) begin : g_iter
        fsqrt_stage #(
            .BIT_POS(NUM_ITERS - 1 - k)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (st_valid[k]),
            .i_work  (st_work[k]),
            .i_side  (st_side[k]),
            .o_valid (st_valid[k+1]),
            .o_work  (st_work[k+1]),
            .o_side  (st_side[k+1])
        );
    end

    // round and pack
    t_side            l_side;
    t_work            l_work;
    logic             sticky;
    logic [ROOT_W-1:0] rnd_root;
    logic [31:0]      packed_res;
    logic [31:0]      n_bits;
    logic             n_inv;
    logic             n_inx;

    always_comb begin
        l_side     = st_side[NUM_ITERS];
        l_work     = st_work[NUM_ITERS];
        sticky     = (l_work.rem != '0);
        rnd_root   = l_work.root + (sticky ? {{(ROOT_W-1){1'b0}}, l_work.root[0]} : '0);
        packed_res = 32'(rnd_root >> 1) + {1'b0, l_side.exp_base, 23'd0};
        if (l_side.special) begin
            n_bits = l_side.spec_bits;
            n_inv  = l_side.spec_inv;
            n_inx  = 1'b0;
        end else begin
            n_bits = packed_res;
            n_inv  = 1'b0;
            n_inx  = sticky;
        end
    end

    logic        r_out_valid;
    logic [31:0] r_out_bits;
    logic        r_out_inv;
    logic        r_out_inx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= st_valid[NUM_ITERS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_bits <= n_bits;
            r_out_inv  <= n_inv;
            r_out_inx  <= n_inx;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_root_bits = r_out_bits;
    assign o_invalid   = r_out_inv;
    assign o_inexact   = r_out_inx;
endmodule
